// ===== hdl/calendar_date_stepper_core_macros.svh =====
// assertion macros for the calendar date stepper
`ifndef CALENDAR_DATE_STEPPER_CORE_MACROS_SVH
`define CALENDAR_DATE_STEPPER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define CDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define CDS_ASSERT_NEVER(lbl, cond, msg) \
	`CDS_ASSERT(lbl, !(cond), msg)

`endif

// ===== hdl/cds_pkg.sv =====
// types, codes and calendar helpers shared by the date stepper modules
package cds_pkg;

	typedef enum logic [2:0] {
		OP_PREV_MONTH = 3'd0,
		OP_NEXT_MONTH = 3'd1,
		OP_PREV_DAY   = 3'd2,
		OP_NEXT_DAY   = 3'd3,
		OP_LOAD       = 3'd4
	} op_e;

	typedef struct packed {
		logic [2:0]  op;
		logic [13:0] load_year;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
	} req_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  days_in_month;
	} rsp_t;

	// request after load clamping, with the century of the load year
	typedef struct packed {
		logic [2:0]  op;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [6:0]  cent;
	} prep_t;

	localparam logic [13:0] YEAR_MAX    = 14'd9999;
	localparam logic [13:0] YEAR_RESET  = 14'd2000;
	localparam logic [6:0]  YY_RESET    = 7'd0;
	localparam logic [6:0]  CENT_RESET  = 7'd20;
	localparam logic [6:0]  YY_MAX      = 7'd99;
	localparam logic [6:0]  CENT_MAX    = 7'd99;
	localparam logic [3:0]  MONTHS      = 4'd12;
	localparam logic [3:0]  MONTH_FIRST = 4'd1;
	localparam logic [3:0]  MONTH_FEB   = 4'd2;
	localparam logic [4:0]  DAY_FIRST   = 5'd1;
	// floor(y / 100) == (y * CENT_RECIP) >> CENT_SHIFT for y below 16384
	localparam logic [12:0] CENT_RECIP  = 13'd5243;
	localparam int          CENT_SHIFT  = 19;

	function automatic logic leap_year(input logic [6:0] yy, input logic [6:0] cent);
		logic div4;
		div4 = (yy[1:0] == 2'd0);
		return div4 && ((yy != 7'd0) || (cent[1:0] == 2'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m == MONTH_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage

// ===== hdl/cds_req_stage.sv =====
// request register and load clamping stage
module cds_req_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cds_pkg::req_t in_req,
	output logic          out_valid,
	input  logic          out_ready,
	output cds_pkg::prep_t out_prep
);
	import cds_pkg::*;

	logic        s1_v_q;
	req_t        req_s1;
	logic        s2_v_q;
	prep_t       prep_s2;
	logic        s2_ready;
	prep_t       prep_d;
	logic [13:0] sat_year;
	logic [26:0] cent_prod;

	assign s2_ready = !s2_v_q || out_ready;
	assign in_ready = !s1_v_q || s2_ready;

	always_comb begin
		sat_year = (req_s1.load_year > YEAR_MAX) ? YEAR_MAX : req_s1.load_year;
		cent_prod = {13'd0, sat_year} * {14'd0, CENT_RECIP};
		prep_d.op = req_s1.op;
		prep_d.year = sat_year;
		if (req_s1.load_month == 4'd0) begin
			prep_d.month = MONTH_FIRST;
		end else if (req_s1.load_month > MONTHS) begin
			prep_d.month = MONTHS;
		end else begin
			prep_d.month = req_s1.load_month;
		end
		prep_d.day = (req_s1.load_day == 5'd0) ? DAY_FIRST : req_s1.load_day;
		prep_d.cent = cent_prod[CENT_SHIFT +: 7];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_v_q <= in_valid;
			end
			if (s2_ready) begin
				s2_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
		if (s1_v_q && s2_ready) begin
			prep_s2 <= prep_d;
		end
	end

	assign out_valid = s2_v_q;
	assign out_prep = prep_s2;

endmodule

// ===== hdl/cds_date_update.sv =====
// date state, step logic and result register
`include "calendar_date_stepper_core_macros.svh"

module cds_date_update (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cds_pkg::prep_t in_prep,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cds_pkg::rsp_t  rsp
);
	import cds_pkg::*;

	logic [13:0] year_q;
	logic [6:0]  yy_q;
	logic [6:0]  cent_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  dim_q;
	logic        rsp_valid_q;

	logic        advance;
	logic        cur_leap;
	logic [4:0]  cur_len;
	logic [3:0]  last_month;
	logic [13:0] fwd_year;
	logic [6:0]  fwd_yy;
	logic [6:0]  fwd_cent;
	logic [13:0] back_year;
	logic [6:0]  back_yy;
	logic [6:0]  back_cent;
	logic [13:0] cent_x100;
	logic [13:0] load_yy_wide;
	logic        mon_fwd;
	logic        mon_back;
	logic [13:0] year_n;
	logic [6:0]  yy_n;
	logic [6:0]  cent_n;
	logic [3:0]  month_n;
	logic [4:0]  day_n;

	assign in_ready = !rsp_valid_q || rsp_ready;
	assign advance = in_valid && in_ready;

	always_comb begin
		cur_leap = leap_year(yy_q, cent_q);
		cur_len = month_len(month_q, cur_leap);
		last_month = (month_q <= MONTH_FIRST) ? MONTHS : month_q - 4'd1;

		// year plus one and year minus one, each with its split into century and year of century
		if (year_q >= YEAR_MAX) begin
			fwd_year = 14'd0;
			fwd_yy = 7'd0;
			fwd_cent = 7'd0;
		end else begin
			fwd_year = year_q + 14'd1;
			fwd_yy = (yy_q == YY_MAX) ? 7'd0 : yy_q + 7'd1;
			fwd_cent = (yy_q == YY_MAX) ? cent_q + 7'd1 : cent_q;
		end
		if (year_q == 14'd0) begin
			back_year = YEAR_MAX;
			back_yy = YY_MAX;
			back_cent = CENT_MAX;
		end else begin
			back_year = year_q - 14'd1;
			back_yy = (yy_q == 7'd0) ? YY_MAX : yy_q - 7'd1;
			back_cent = (yy_q == 7'd0) ? cent_q - 7'd1 : cent_q;
		end

		cent_x100 = {1'b0, in_prep.cent, 6'd0} + {2'b0, in_prep.cent, 5'd0}
			+ {5'd0, in_prep.cent, 2'd0};
		load_yy_wide = in_prep.year - cent_x100;

		mon_fwd = 1'b0;
		mon_back = 1'b0;
		year_n = year_q;
		yy_n = yy_q;
		cent_n = cent_q;
		month_n = month_q;
		day_n = day_q;

		case (in_prep.op)
			OP_PREV_MONTH: begin
				mon_back = 1'b1;
			end
			OP_NEXT_MONTH: begin
				mon_fwd = 1'b1;
			end
			OP_PREV_DAY: begin
				if (day_q <= DAY_FIRST) begin
					day_n = month_len(last_month, cur_leap);
					mon_back = 1'b1;
				end else begin
					day_n = day_q - 5'd1;
				end
			end
			OP_NEXT_DAY: begin
				if (day_q >= cur_len) begin
					day_n = DAY_FIRST;
					mon_fwd = 1'b1;
				end else begin
					day_n = day_q + 5'd1;
				end
			end
			OP_LOAD: begin
				year_n = in_prep.year;
				yy_n = load_yy_wide[6:0];
				cent_n = in_prep.cent;
				month_n = in_prep.month;
				day_n = in_prep.day;
			end
			default: begin
			end
		endcase

		if (mon_fwd) begin
			if (month_q >= MONTHS) begin
				month_n = MONTH_FIRST;
				year_n = fwd_year;
				yy_n = fwd_yy;
				cent_n = fwd_cent;
			end else begin
				month_n = month_q + 4'd1;
			end
		end
		if (mon_back) begin
			if (month_q <= MONTH_FIRST) begin
				month_n = MONTHS;
				year_n = back_year;
				yy_n = back_yy;
				cent_n = back_cent;
			end else begin
				month_n = month_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q <= YEAR_RESET;
			yy_q <= YY_RESET;
			cent_q <= CENT_RESET;
			month_q <= MONTH_FIRST;
			day_q <= DAY_FIRST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				rsp_valid_q <= in_valid;
			end
			if (advance) begin
				year_q <= year_n;
				yy_q <= yy_n;
				cent_q <= cent_n;
				month_q <= month_n;
				day_q <= day_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dim_q <= month_len(month_n, leap_year(yy_n, cent_n));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp.year = year_q;
	assign rsp.month = month_q;
	assign rsp.day = day_q;
	assign rsp.days_in_month = dim_q;

	`CDS_ASSERT(a_year_split, year_q == ({7'd0, cent_q} * 14'd100 + {7'd0, yy_q}), "year split out of step")
	`CDS_ASSERT(a_hold_state, !advance |=> $stable(year_q) && $stable(month_q) && $stable(day_q), "date moved without a request")
	`CDS_ASSERT_NEVER(a_month_range, month_q == 4'd0 || month_q > MONTHS || day_q == 5'd0, "date out of range")
	`CDS_ASSERT_NEVER(a_dim_range, rsp_valid_q && (dim_q < 5'd28 || (dim_q == 5'd29 && month_q != MONTH_FEB)), "bad month length")

endmodule

// ===== hdl/calendar_date_stepper_core.sv =====
// top level of the calendar date stepper
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   op, load_year, load_month, load_day
//   rsp      out        rsp_valid/rsp_ready   year, month, day, days_in_month
//
// one request per cycle sustained while rsp_ready is held high
// two request stages and the date register with its result register form the pipe
// reset gives 2000-01-01 and empty stages
// a stalled result holds the pipe; ready runs back through each stage
module calendar_date_stepper_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cds_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cds_pkg::rsp_t rsp
);
	import cds_pkg::*;

	logic  prep_valid;
	logic  prep_ready;
	prep_t prep;

	cds_req_stage u_req_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.in_req    (req),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.out_prep  (prep)
	);

	cds_date_update u_date_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.in_prep   (prep),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
